### rtl/sops_pkg.sv
// Shared types and constants for the odd-only segmented prime sieve.
`timescale 1ns / 1ps
package sops_pkg;

	localparam int WORD_BITS  = 64;
	localparam int MAX_WORDS  = 64;
	localparam int SEG_ADDR_W = 6;
	localparam int KEEP_MAX   = WORD_BITS * MAX_WORDS;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_BI,
		ST_BM,
		ST_BC,
		ST_BW,
		ST_IDLE,
		ST_SR,
		ST_OOR,
		ST_SI,
		ST_SM,
		ST_SC,
		ST_DV,
		ST_DF,
		ST_X,
		ST_EM,
		ST_EW
	} sops_state_t;

endpackage

### rtl/sops_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module sops_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/segmented_odd_prime_sieve.sv
// Top level of the odd-only segmented sieve of Eratosthenes.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready/sieve_limit) writes the limit; always ready.
//   in channel (in_valid/in_ready/segment_index) takes one segment request.
//   out channel (out_valid/out_ready) returns 64-bit words, 1 bit = prime,
//   word_index counting up, last_word on the final word of the request.
//   A segment whose start exceeds the limit returns one word with
//   out_of_range set and prime_bits zero.
// Reset: the base mark table is cleared and then sieved; in_ready stays low
//   until that is done.
// Throughput: one request at a time. Per base prime: the SI, SM and SC steps,
//   plus the bit-serial remainder unit (DV, DF) when p*p lies below
//   the segment start, plus crossings at one per cycle (pipelined read-modify-write
//   on the segment word memory with forwarding). Emission passes through the EM
//   and EW states for each word. A stalled receiver holds the output
//   register; the block waits before loading the next word.
`timescale 1ns / 1ps
module segmented_odd_prime_sieve #(
	parameter int SEG_BITS         = 4096,
	parameter int BASE_ODD_ENTRIES = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] sieve_limit,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [18:0] segment_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] prime_bits,
	output logic [5:0]  word_index,
	output logic        last_word,
	output logic        out_of_range
);
	import sops_pkg::*;

	localparam int N    = BASE_ODD_ENTRIES;
	localparam int AW   = $clog2(N);
	localparam int PW   = $clog2(2 * N + 2);
	localparam int PPW  = 2 * PW;
	localparam int JW   = AW + 2;
	localparam int LW   = $clog2(SEG_BITS) + 21;
	localparam int CW   = (LW > PPW) ? LW : PPW;
	localparam int RW   = (LW > 32) ? LW : 32;
	localparam int IW   = (($clog2(SEG_BITS) > PW) ? $clog2(SEG_BITS) : PW) + 1;
	localparam int CNW  = $clog2(LW);
	localparam int TOP  = 2 * (N - 1) + 3;
	localparam int KEEP = (SEG_BITS < KEEP_MAX) ? SEG_BITS : KEEP_MAX;
	localparam int WRDS = ((SEG_BITS + 63) / 64 < MAX_WORDS) ? (SEG_BITS + 63) / 64 : MAX_WORDS;
	localparam logic [63:0] LAST_MASK = (SEG_BITS % 64 != 0 && SEG_BITS < KEEP_MAX) ?
		((64'd1 << (SEG_BITS % 64)) - 64'd1) : {64{1'b1}};

	sops_state_t state_q, state_d;

	logic [AW:0]           i_q;
	logic [PW-1:0]         p_q;
	logic [PPW-1:0]        pp_q;
	logic [JW-1:0]         j_q;
	logic [LW-1:0]         low_q, high_q;
	logic [PW-1:0]         rem_q;
	logic [CNW-1:0]        cnt_q;
	logic [IW-1:0]         idx_q;
	logic [SEG_ADDR_W-1:0] w_q;
	logic [31:0]           limit_q;
	logic [MAX_WORDS-1:0]  segv_q;

	logic                  v_s1;
	logic [SEG_ADDR_W-1:0] a_s1;
	logic [5:0]            b_s1;
	logic                  fwd_v_q;
	logic [SEG_ADDR_W-1:0] fwd_a_q;
	logic [63:0]           fwd_d_q;

	logic        out_valid_q;
	logic [63:0] bits_q;
	logic [5:0]  widx_q;
	logic        last_q, oor_q;

	logic          b_we, b_wdata, b_rdata;
	logic [AW-1:0] b_waddr, b_raddr;
	logic                  s_we;
	logic [SEG_ADDR_W-1:0] s_raddr;
	logic [63:0]           s_wdata, s_rdata, s_old;

	logic          slot_free;
	logic          pp_gt_top, pp_gt_high, pp_ge_low, low_gt_lim, i_end, x_go, j_in;
	logic [PW:0]   sh, off0, off;
	logic          sh_ge;

	sops_ram #(.WIDTH(1), .DEPTH(N)) u_base (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.raddr(b_raddr), .rdata(b_rdata)
	);

	sops_ram #(.WIDTH(64), .DEPTH(MAX_WORDS)) u_seg (
		.clk(clk), .we(s_we), .waddr(a_s1), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	assign slot_free  = !out_valid_q || out_ready;
	assign pp_gt_top  = pp_q > PPW'(TOP);
	assign pp_gt_high = CW'(pp_q) > CW'(high_q);
	assign pp_ge_low  = CW'(pp_q) >= CW'(low_q);
	assign low_gt_lim = RW'(low_q) > RW'(limit_q);
	assign i_end      = i_q == (AW + 1)'(N);
	assign x_go       = idx_q < IW'(KEEP);
	assign j_in       = j_q < JW'(N);
	assign sh         = {rem_q, low_q[cnt_q]};
	assign sh_ge      = sh >= {1'b0, p_q};
	assign off0       = (rem_q == '0) ? '0 : ({1'b0, p_q} - {1'b0, rem_q});
	assign off        = off0[0] ? (off0 + {1'b0, p_q}) : off0;

	assign s_old   = (fwd_v_q && fwd_a_q == a_s1) ? fwd_d_q :
		(segv_q[a_s1] ? s_rdata : 64'd0);
	assign s_wdata = s_old | (64'd1 << b_s1);
	assign s_we    = v_s1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR:  if (i_q == (AW + 1)'(N - 1)) state_d = ST_BI;
			ST_BI:   state_d = ST_BM;
			ST_BM:   state_d = ST_BC;
			ST_BC: begin
				if (pp_gt_top) state_d = ST_IDLE;
				else if (b_rdata) state_d = ST_BI;
				else state_d = ST_BW;
			end
			ST_BW:   if (!j_in) state_d = ST_BI;
			ST_IDLE: if (in_valid) state_d = ST_SR;
			ST_SR:   state_d = low_gt_lim ? ST_OOR : ST_SI;
			ST_OOR:  if (slot_free) state_d = ST_IDLE;
			ST_SI:   state_d = i_end ? ST_EM : ST_SM;
			ST_SM:   state_d = ST_SC;
			ST_SC: begin
				if (pp_gt_high) state_d = ST_EM;
				else if (b_rdata) state_d = ST_SI;
				else if (pp_ge_low) state_d = ST_X;
				else state_d = ST_DV;
			end
			ST_DV:   if (cnt_q == '0) state_d = ST_DF;
			ST_DF:   state_d = ST_X;
			ST_X:    if (!x_go) state_d = ST_SI;
			ST_EM:   state_d = ST_EW;
			ST_EW: begin
				if (slot_free) state_d = (w_q == SEG_ADDR_W'(WRDS - 1)) ? ST_IDLE : ST_EM;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		b_we    = 1'b0;
		b_wdata = 1'b0;
		b_waddr = i_q[AW-1:0];
		b_raddr = i_q[AW-1:0];
		s_raddr = w_q;
		in_ready = state_q == ST_IDLE;
		unique case (state_q)
			ST_CLR:  b_we = 1'b1;
			ST_BW: begin
				b_we    = j_in;
				b_wdata = 1'b1;
				b_waddr = j_q[AW-1:0];
			end
			ST_X:    s_raddr = SEG_ADDR_W'(idx_q >> 6);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			i_q         <= '0;
			limit_q     <= 32'd65536;
			segv_q      <= '0;
			v_s1        <= 1'b0;
			fwd_v_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) limit_q <= sieve_limit;
			if ((state_q == ST_OOR || state_q == ST_EW) && slot_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			v_s1    <= (state_q == ST_X) && x_go;
			fwd_v_q <= v_s1;
			if (state_q == ST_SR) segv_q <= '0;
			else if (v_s1) segv_q[a_s1] <= 1'b1;
			unique case (state_q)
				ST_CLR:  i_q <= (i_q == (AW + 1)'(N - 1)) ? '0 : i_q + 1'b1;
				ST_BC: begin
					if (pp_gt_top) i_q <= '0;
					else if (b_rdata) i_q <= i_q + 1'b1;
				end
				ST_BW:   if (!j_in) i_q <= i_q + 1'b1;
				ST_SR:   i_q <= '0;
				ST_SC: begin
					if (!pp_gt_high && b_rdata) i_q <= i_q + 1'b1;
				end
				ST_X:    if (!x_go) i_q <= i_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= SEG_ADDR_W'(idx_q >> 6);
		b_s1    <= idx_q[5:0];
		fwd_a_q <= a_s1;
		fwd_d_q <= s_wdata;
		unique case (state_q)
			ST_BI, ST_SI: p_q <= PW'({i_q, 1'b1} + (AW + 2)'(2));
			ST_BM, ST_SM: pp_q <= p_q * p_q;
			ST_BC:   j_q <= JW'((pp_q - PPW'(3)) >> 1);
			ST_BW:   j_q <= j_q + JW'(p_q);
			ST_IDLE: begin
				low_q <= LW'(3) + LW'(segment_index) * LW'(2 * SEG_BITS);
				w_q   <= '0;
			end
			ST_SR:   high_q <= low_q + LW'(2 * SEG_BITS - 1);
			ST_OOR: begin
				if (slot_free) begin
					bits_q <= '0;
					widx_q <= '0;
					last_q <= 1'b1;
					oor_q  <= 1'b1;
				end
			end
			ST_SC: begin
				idx_q <= IW'((CW'(pp_q) - CW'(low_q)) >> 1);
				rem_q <= '0;
				cnt_q <= CNW'(LW - 1);
			end
			ST_DV: begin
				rem_q <= sh_ge ? PW'(sh - {1'b0, p_q}) : sh[PW-1:0];
				cnt_q <= cnt_q - 1'b1;
			end
			ST_DF:   idx_q <= IW'(off >> 1);
			ST_X:    if (x_go) idx_q <= idx_q + IW'(p_q);
			ST_EW: begin
				if (slot_free) begin
					bits_q <= ~(segv_q[w_q] ? s_rdata : 64'd0) &
						((w_q == SEG_ADDR_W'(WRDS - 1)) ? LAST_MASK : {64{1'b1}});
					widx_q <= w_q;
					last_q <= w_q == SEG_ADDR_W'(WRDS - 1);
					oor_q  <= 1'b0;
					w_q    <= w_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign prime_bits   = bits_q;
	assign word_index   = widx_q;
	assign last_word    = last_q;
	assign out_of_range = oor_q;
endmodule
